@@ rtl/two_level_page_table_top_defines.svh @@
// Assertion macros shared by the two-level page table RTL.
`ifndef TWO_LEVEL_PAGE_TABLE_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside of reset.
`define TLPT_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page table assertion failed");

// Next-cycle implication, checked outside of reset.
`define TLPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page table assertion failed");

`else

`define TLPT_ASSERT(label, clk, rst, ante, cons)
`define TLPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/tlpt_pkg.sv @@
// Types and codes shared by the two-level page table modules.
package tlpt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LK_READ,
      ST_LK_EVAL,
      ST_MAP_CHECK,
      ST_CLEAR,
      ST_MAP_READ,
      ST_MAP_WRITE,
      ST_DONE
   } state_type;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_MAP    = 1'b1;

   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_MAP  = 2'd2;

   localparam logic [1:0] CACHE_NONE = 2'd0;
   localparam logic [1:0] CACHE_WT   = 2'd2;

endpackage

@@ rtl/tlpt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module tlpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/two_level_page_table_top.sv @@
// Two-level page table: a present bit per top-level slot and one RAM of page entries.
//
// A request is taken only while the sequencer is idle; the next request may be taken while
// the previous response still waits on the response port. A lookup goes from request to
// response through one RAM read, one evaluation step and the load of the response
// register. A map handles each page with a check, a RAM read and a RAM write, since no-cache
// mode needs the old write-through bit; for each top-level slot that the run touches for the
// first time, the sequencer first sweeps that slot's entries invalid one per cycle. After
// the response the sequencer returns to idle before it takes the next request, and a
// response that is still held downstream stalls the sequencer in its last step. A map
// handles one page at a time through the single RAM port pair and the one page increment
// unit. No clearing pass follows reset: slots are cleared on first use.
module two_level_page_table_top #(
   parameter int TOP_BITS  = 4,
   parameter int BOT_BITS  = 10,
   parameter int PHYS_BITS = 17,
   localparam int VA_W     = TOP_BITS + BOT_BITS,
   localparam int CNT_W    = VA_W + 1,
   localparam int REQ_RAW  = VA_W + PHYS_BITS + CNT_W + 5,
   localparam int REQ_W    = ((REQ_RAW + 7) / 8) * 8,
   localparam int ENTRY_W  = PHYS_BITS + 5,
   localparam int RSP_W    = ((ENTRY_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // virt_page, phys_page, page_count, prot_key, cache_mode, shared_in, zero fill
   input  logic [REQ_W-1:0] req_tdata,
   // func
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // phys_out, prot_out, write_through, dirty_out, shared_out, zero fill
   output logic [RSP_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   `include "two_level_page_table_top_defines.svh"

   localparam int NTOP     = 1 << TOP_BITS;
   localparam int NPAGES   = 1 << VA_W;
   localparam int RAM_W    = ENTRY_W + 1;
   localparam int E_WT     = PHYS_BITS + 2;
   localparam int E_VALID  = PHYS_BITS + 5;
   localparam int F_PHYS   = VA_W;
   localparam int F_COUNT  = F_PHYS + PHYS_BITS;
   localparam int F_PROT   = F_COUNT + CNT_W;
   localparam int F_MODE   = F_PROT + 2;
   localparam int F_SHARED = F_MODE + 2;

   tlpt_pkg::state_type state_ff, state_in;

   logic                 func_ff;
   logic [VA_W-1:0]      vidx_ff;
   logic [PHYS_BITS-1:0] phys_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [1:0]           prot_ff;
   logic [1:0]           mode_ff;
   logic                 shared_ff;
   logic [BOT_BITS-1:0]  clr_ff;
   logic [NTOP-1:0]      top_present_ff;
   logic [1:0]           res_status_ff;
   logic [ENTRY_W-1:0]   res_entry_ff;
   logic                 rsp_tvalid_ff;
   logic [1:0]           rsp_tuser_ff;
   logic [ENTRY_W-1:0]   rsp_entry_ff;

   logic [TOP_BITS-1:0]  top_idx;
   logic                 clr_last;
   logic                 rsp_free;
   logic                 hit;
   logic                 wt_new;
   logic                 ram_we;
   logic [VA_W-1:0]      ram_waddr;
   logic [RAM_W-1:0]     ram_wdata;
   logic [RAM_W-1:0]     ram_rdata;

   assign top_idx  = vidx_ff[VA_W-1 -: TOP_BITS];
   assign clr_last = &clr_ff;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign hit      = top_present_ff[top_idx] && ram_rdata[E_VALID];

   tlpt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NPAGES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (vidx_ff),
      .rd_data (ram_rdata)
   );

   // Write-through bit for a mapped page; no-cache mode keeps the old bit of a valid entry.
   always_comb begin
      case (mode_ff)
         tlpt_pkg::CACHE_NONE: wt_new = ram_rdata[E_VALID] && ram_rdata[E_WT];
         tlpt_pkg::CACHE_WT:   wt_new = 1'b1;
         default:              wt_new = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlpt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == tlpt_pkg::FUNC_MAP) ? tlpt_pkg::ST_MAP_CHECK
                                                           : tlpt_pkg::ST_LK_READ;
            end
         end
         tlpt_pkg::ST_LK_READ:   state_in = tlpt_pkg::ST_LK_EVAL;
         tlpt_pkg::ST_LK_EVAL:   state_in = tlpt_pkg::ST_DONE;
         tlpt_pkg::ST_MAP_CHECK: begin
            if (count_ff == '0) begin
               state_in = tlpt_pkg::ST_DONE;
            end else if (!top_present_ff[top_idx]) begin
               state_in = tlpt_pkg::ST_CLEAR;
            end else begin
               state_in = tlpt_pkg::ST_MAP_READ;
            end
         end
         tlpt_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = tlpt_pkg::ST_MAP_READ;
            end
         end
         tlpt_pkg::ST_MAP_READ:  state_in = tlpt_pkg::ST_MAP_WRITE;
         tlpt_pkg::ST_MAP_WRITE: state_in = tlpt_pkg::ST_MAP_CHECK;
         tlpt_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tlpt_pkg::ST_IDLE;
            end
         end
         default: state_in = tlpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = vidx_ff;
      ram_wdata  = '0;
      unique case (state_ff)
         tlpt_pkg::ST_IDLE: req_tready = 1'b1;
         tlpt_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = {top_idx, clr_ff};
         end
         tlpt_pkg::ST_MAP_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, shared_ff, 1'b1, wt_new, prot_ff, phys_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tlpt_pkg::ST_IDLE;
         top_present_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tlpt_pkg::ST_CLEAR && clr_last) begin
            top_present_ff[top_idx] <= 1'b1;
         end
         if (state_ff == tlpt_pkg::ST_DONE && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         tlpt_pkg::ST_IDLE: begin
            func_ff   <= req_tuser;
            vidx_ff   <= req_tdata[VA_W-1:0];
            phys_ff   <= req_tdata[F_PHYS +: PHYS_BITS];
            count_ff  <= req_tdata[F_COUNT +: CNT_W];
            prot_ff   <= req_tdata[F_PROT +: 2];
            mode_ff   <= req_tdata[F_MODE +: 2];
            shared_ff <= req_tdata[F_SHARED];
            clr_ff    <= '0;
         end
         tlpt_pkg::ST_LK_EVAL: begin
            res_status_ff <= hit ? tlpt_pkg::STATUS_HIT : tlpt_pkg::STATUS_MISS;
            res_entry_ff  <= hit ? ram_rdata[ENTRY_W-1:0] : '0;
         end
         tlpt_pkg::ST_MAP_CHECK: begin
            res_status_ff <= tlpt_pkg::STATUS_MAP;
            res_entry_ff  <= '0;
         end
         tlpt_pkg::ST_CLEAR: begin
            clr_ff <= clr_ff + BOT_BITS'(1);
         end
         tlpt_pkg::ST_MAP_WRITE: begin
            vidx_ff  <= vidx_ff + VA_W'(1);
            phys_ff  <= phys_ff + PHYS_BITS'(1);
            count_ff <= count_ff - CNT_W'(1);
         end
         tlpt_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_tuser_ff <= res_status_ff;
               rsp_entry_ff <= res_entry_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = RSP_W'(rsp_entry_ff);

   `TLPT_ASSERT(a_ram_write_in_map, clock, reset, ram_we,
      (state_ff == tlpt_pkg::ST_CLEAR || state_ff == tlpt_pkg::ST_MAP_WRITE) && func_ff)
   `TLPT_ASSERT_NEXT(a_slot_present_after_clear, clock, reset,
      state_ff == tlpt_pkg::ST_CLEAR && clr_last, top_present_ff[top_idx])
   `TLPT_ASSERT_NEXT(a_count_steps_down, clock, reset,
      state_ff == tlpt_pkg::ST_MAP_WRITE, count_ff == $past(count_ff) - CNT_W'(1))
   `TLPT_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff) == tlpt_pkg::ST_DONE)

endmodule
